FILE: rtl/core/csf_pkg.sv
// Shared constants, types and register indexes of the cross kernel sharpen filter.
// Used by every module of the block but csf_ram; depends on nothing.
`timescale 1ns / 1ps

package csf_pkg;

  // Frame limits.
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Field and register widths.
  localparam int PIX_W   = 32;
  localparam int STORE_W = PIX_W + 1;
  localparam int CFG_W   = 13;
  localparam int AMT_W   = 5;
  localparam int IDX_W   = 2;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_SHARPEN_AMOUNT = 2'd2;

  // Reset values of the registers.
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 13'd640;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 13'd480;
  localparam logic [AMT_W-1:0] RST_SHARPEN_AMOUNT = 5'd2;

  // Input commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // One pending result with its neighbourhood resolved.
  typedef struct packed {
    logic [PIX_W-1:0] mid_px;
    logic             mid_sel;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic             frame_end;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              not_empty;
  } queue_status_t;

endpackage

FILE: rtl/core/csf_ram.sv
// Generic simple RAM: one write port and two read ports with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module csf_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1,
  output logic [WIDTH-1:0]                          rdata0,
  output logic [WIDTH-1:0]                          rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Reads return the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

FILE: rtl/core/csf_queue.sv
// Short register queue of resolved neighbourhoods between the front and the back.
// Depends on csf_pkg for the entry type and the depth.
`timescale 1ns / 1ps

module csf_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  csf_pkg::push_t         push,
  input  logic                   pop,
  output csf_pkg::entry_t        head,
  output csf_pkg::queue_status_t status
);

  csf_pkg::entry_t                 slots [csf_pkg::QDEPTH];
  logic [csf_pkg::QPTR_W-1:0]      wr_ptr;
  logic [csf_pkg::QPTR_W-1:0]      rd_ptr;
  logic [csf_pkg::QCNT_W-1:0]      count;

  function automatic logic [csf_pkg::QPTR_W-1:0] bump(input logic [csf_pkg::QPTR_W-1:0] p);
    if (p == csf_pkg::QPTR_W'(csf_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      unique case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  assign head             = slots[rd_ptr];
  assign status.count     = count;
  assign status.not_empty = (count != '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && !pop && count == csf_pkg::QCNT_W'(csf_pkg::QDEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");

endmodule

FILE: rtl/core/csf_front.sv
// Front of the sharpen filter: accepts and classifies items, keeps the raster position,
// owns the two row stores and resolves each neighbourhood. Depends on csf_pkg, csf_ram.
`timescale 1ns / 1ps

module csf_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [csf_pkg::PIX_W-1:0]   pixel_in,
  input  logic                        selected,
  input  logic [csf_pkg::CFG_W-1:0]   image_width,
  input  logic [csf_pkg::CFG_W-1:0]   image_height,
  input  csf_pkg::queue_status_t      qs,
  output csf_pkg::push_t              push
);

  typedef struct packed {
    logic                      valid;
    logic                      up_from_older;
    logic                      down_given;
    logic [csf_pkg::PIX_W-1:0] down_px;
    logic                      frame_end;
    logic                      bank;
  } read_stage_t;

  logic [csf_pkg::COL_W-1:0]   column_count;
  logic [csf_pkg::ROW_W-1:0]   row_count;
  logic                        drain_pending;
  logic                        newer_sel;
  read_stage_t                 d1;

  logic [csf_pkg::COL_W-1:0]   wm1;
  logic [csf_pkg::ROW_W-1:0]   hm1;
  logic [csf_pkg::COL_W-1:0]   x;
  logic [csf_pkg::COL_W-1:0]   xl;
  logic [csf_pkg::COL_W-1:0]   xr;
  logic                        row_end;
  logic                        frame_last;
  logic                        accept;
  logic                        do_pix;
  logic                        do_drain;
  logic                        emit;
  logic [csf_pkg::QCNT_W:0]    occupancy;
  logic [1:0]                  bank_we;
  logic [csf_pkg::STORE_W-1:0] wdata;
  logic [csf_pkg::STORE_W-1:0] rd_a0 [2];
  logic [csf_pkg::STORE_W-1:0] rd_a1 [2];
  logic [csf_pkg::STORE_W-1:0] rd_b0 [2];
  logic [csf_pkg::STORE_W-1:0] rd_b1 [2];
  logic [csf_pkg::STORE_W-1:0] mid;
  logic [csf_pkg::STORE_W-1:0] up_old;

  // Effective geometry, clamped to the supported frame.
  always_comb begin
    if (image_width == '0) begin
      wm1 = '0;
    end else if (32'(image_width) > 32'(csf_pkg::MAX_WIDTH)) begin
      wm1 = csf_pkg::COL_W'(csf_pkg::MAX_WIDTH - 1);
    end else begin
      wm1 = csf_pkg::COL_W'(image_width - 1'b1);
    end
    if (image_height == '0) begin
      hm1 = '0;
    end else if (32'(image_height) > 32'(csf_pkg::MAX_HEIGHT)) begin
      hm1 = csf_pkg::ROW_W'(csf_pkg::MAX_HEIGHT - 1);
    end else begin
      hm1 = csf_pkg::ROW_W'(image_height - 1'b1);
    end
  end

  assign x          = (column_count > wm1) ? wm1 : column_count;
  assign xl         = (x == '0) ? '0 : x - 1'b1;
  assign xr         = (x >= wm1) ? wm1 : x + 1'b1;
  assign row_end    = (column_count >= wm1);
  assign frame_last = (row_count >= hm1);

  // Space is reserved in the queue for the item in the read stage.
  assign occupancy = {1'b0, qs.count} + (csf_pkg::QCNT_W + 1)'(d1.valid);
  assign in_stall  = (occupancy >= (csf_pkg::QCNT_W + 1)'(csf_pkg::QDEPTH));

  assign accept   = in_valid && !in_stall;
  assign do_pix   = accept && (command == csf_pkg::CMD_PIXEL) && !drain_pending;
  assign do_drain = accept && (command == csf_pkg::CMD_DRAIN) && drain_pending;
  assign emit     = (do_pix && row_count != '0) || do_drain;

  // The incoming row goes to the bank that holds the older row.
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      bank_we[b] = do_pix && (newer_sel != 1'(b));
    end
  end
  assign wdata = {selected, pixel_in};

  // Each bank has two copies so that three columns of the newer row can be read at once.
  for (genvar b = 0; b < 2; b++) begin : g_bank
    csf_ram #(.WIDTH(csf_pkg::STORE_W), .DEPTH(csf_pkg::MAX_WIDTH)) u_copy_a (
      .clk    (clk),
      .we     (bank_we[b]),
      .waddr  (x),
      .wdata  (wdata),
      .raddr0 (x),
      .raddr1 (xr),
      .rdata0 (rd_a0[b]),
      .rdata1 (rd_a1[b])
    );
    csf_ram #(.WIDTH(csf_pkg::STORE_W), .DEPTH(csf_pkg::MAX_WIDTH)) u_copy_b (
      .clk    (clk),
      .we     (bank_we[b]),
      .waddr  (x),
      .wdata  (wdata),
      .raddr0 (xl),
      .raddr1 (x),
      .rdata0 (rd_b0[b]),
      .rdata1 (rd_b1[b])
    );
  end

  always_ff @(posedge clk) begin
    // Read-stage payload travels with the store reads issued at the same edge.
    d1.up_from_older <= drain_pending ? (row_count != '0) : (row_count > csf_pkg::ROW_W'(1));
    d1.down_given    <= !drain_pending;
    d1.down_px       <= pixel_in;
    d1.frame_end     <= drain_pending && row_end;
    d1.bank          <= newer_sel;
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      drain_pending <= 1'b0;
      newer_sel     <= 1'b0;
      d1.valid      <= 1'b0;
    end else begin
      d1.valid <= emit;
      if (do_pix) begin
        if (row_end) begin
          column_count <= '0;
          newer_sel    <= ~newer_sel;
          if (frame_last) begin
            drain_pending <= 1'b1;
          end else begin
            row_count <= row_count + 1'b1;
          end
        end else begin
          column_count <= column_count + 1'b1;
        end
      end else if (do_drain) begin
        if (row_end) begin
          column_count  <= '0;
          row_count     <= '0;
          drain_pending <= 1'b0;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

  assign mid    = rd_a0[d1.bank];
  assign up_old = rd_b1[~d1.bank];

  always_comb begin
    push.valid           = d1.valid;
    push.entry.mid_px    = mid[csf_pkg::PIX_W-1:0];
    push.entry.mid_sel   = mid[csf_pkg::PIX_W];
    push.entry.up        = d1.up_from_older ? up_old[csf_pkg::PIX_W-1:0]
                                            : mid[csf_pkg::PIX_W-1:0];
    push.entry.down      = d1.down_given ? d1.down_px : mid[csf_pkg::PIX_W-1:0];
    push.entry.left      = rd_b0[d1.bank][csf_pkg::PIX_W-1:0];
    push.entry.right     = rd_a1[d1.bank][csf_pkg::PIX_W-1:0];
    push.entry.frame_end = d1.frame_end;
  end

  a_room_reserved: assert property (@(posedge clk) disable iff (rst)
    occupancy <= (csf_pkg::QCNT_W + 1)'(csf_pkg::QDEPTH))
    else $error("more items in flight than queue slots");

  a_first_row_silent: assert property (@(posedge clk) disable iff (rst)
    (do_pix && row_count == '0) |=> !d1.valid)
    else $error("result produced for a pixel of the first row");

  a_drain_wraps: assert property (@(posedge clk) disable iff (rst)
    (do_drain && row_end) |=> (!drain_pending && row_count == '0 && column_count == '0))
    else $error("position not cleared at the end of the frame");

endmodule

FILE: rtl/core/csf_sharpen.sv
// Back of the sharpen filter: applies the cross kernel to queued neighbourhoods and
// holds the result register. Depends on csf_pkg.
`timescale 1ns / 1ps

module csf_sharpen (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [csf_pkg::AMT_W-1:0]   sharpen_amount,
  input  csf_pkg::queue_status_t      qs,
  input  csf_pkg::entry_t             head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [csf_pkg::PIX_W-1:0]   pixel_out,
  output logic                        frame_end
);

  // Quarter units: 4*mid*(1+a) - a*(up+down+left+right), clipped and scaled to 8 bits.
  function automatic logic [csf_pkg::PIX_W-1:0] sharpen_px(input csf_pkg::entry_t e,
                                                          input logic [csf_pkg::AMT_W-1:0] amt);
    logic [csf_pkg::PIX_W-1:0] res;
    logic [9:0]                sum;
    logic [15:0]               pos;
    logic [14:0]               neg;
    logic [15:0]               diff;
    logic [13:0]               quarter;
    logic [7:0]                c;
    res = {e.mid_px[31:24], 24'b0};
    for (int ch = 0; ch < 3; ch++) begin
      sum = 10'(e.up[ch*8 +: 8]) + 10'(e.down[ch*8 +: 8])
          + 10'(e.left[ch*8 +: 8]) + 10'(e.right[ch*8 +: 8]);
      pos = 16'({e.mid_px[ch*8 +: 8], 2'b00}) * 16'(6'(amt) + 6'd1);
      neg = 15'(sum) * 15'(amt);
      diff = pos - 16'(neg);
      quarter = diff[15:2];
      if (16'(neg) > pos) begin
        c = 8'd0;
      end else if (quarter > 14'd255) begin
        c = 8'hFF;
      end else begin
        c = quarter[7:0];
      end
      res[ch*8 +: 8] = c;
    end
    if (!e.mid_sel || amt == '0) begin
      res = e.mid_px;
    end
    return res;
  endfunction

  assign pop = qs.not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= qs.not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pixel_out <= sharpen_px(head, sharpen_amount);
      frame_end <= head.frame_end;
    end
  end

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped entry did not reach the result register");

endmodule

FILE: rtl/core/cross_kernel_sharpen_filter.sv
// Cross kernel sharpen filter, top level: configuration registers, front, queue and back.
// Throughput is one pixel or drain transfer per clock while in_stall is low; the front
// reads three columns of the newer row and one of the older row from duplicated row-store
// RAMs at once. A result passes the read stage and queue to the output register, one row
// behind the input position. Synchronous active-high reset clears position, queue and output
// valid and loads the register defaults; the row stores hold no valid data until written.
`timescale 1ns / 1ps

module cross_kernel_sharpen_filter (
  input  logic                        clk,
  input  logic                        rst,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [csf_pkg::PIX_W-1:0]   pixel_in,
  input  logic                        selected,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [csf_pkg::PIX_W-1:0]   pixel_out,
  output logic                        frame_end,
  // Configuration write port.
  input  logic                        cfg_we,
  input  logic [csf_pkg::IDX_W-1:0]   cfg_index,
  input  logic [csf_pkg::CFG_W-1:0]   cfg_data
);

  logic [csf_pkg::CFG_W-1:0] image_width;
  logic [csf_pkg::CFG_W-1:0] image_height;
  logic [csf_pkg::AMT_W-1:0] sharpen_amount;

  csf_pkg::push_t         push;
  csf_pkg::queue_status_t qs;
  csf_pkg::entry_t        head;
  logic                   pop;

  // Configuration registers. Writes to an index past the register list are dropped.
  // Software must change these only while no transfer is in flight; this is not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= csf_pkg::RST_IMAGE_WIDTH;
      image_height   <= csf_pkg::RST_IMAGE_HEIGHT;
      sharpen_amount <= csf_pkg::RST_SHARPEN_AMOUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csf_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data;
        csf_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data;
        csf_pkg::REG_SHARPEN_AMOUNT: sharpen_amount <= cfg_data[csf_pkg::AMT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front takes every input transfer, tracks the raster position and the two row
  // stores, and hands a complete neighbourhood to the queue from its read stage. It stalls
  // its input only when every queue slot is taken or reserved for the item it is reading.
  csf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .pixel_in     (pixel_in),
    .selected     (selected),
    .image_width  (image_width),
    .image_height (image_height),
    .qs           (qs),
    .push         (push)
  );

  // The queue decouples the front from a stalled result channel.
  csf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (qs)
  );

  // The back applies the kernel and keeps the result register, refilling it in the
  // same cycle that a waiting result transfers out.
  csf_sharpen u_sharpen (
    .clk            (clk),
    .rst            (rst),
    .sharpen_amount (sharpen_amount),
    .qs             (qs),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_out      (pixel_out),
    .frame_end      (frame_end)
  );

endmodule
